/* sv/qnl_pkg.sv */
package qnl_pkg;

  // Input and output field widths
  localparam int COMP_W        = 16;
  localparam int WEIGHT_W      = 17;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
  localparam int OUT_W         = 16;
  localparam int FRAC_BITS_DEF = 14;

  // Internal fixed point: unit quaternions are Q30
  localparam int Q_FRAC      = 30;
  localparam int Q_W         = 32;
  localparam int QMAG_W      = 31;
  localparam int IN_SHIFT    = 15;
  localparam int SQ_W        = 31;
  localparam int SUMSQ_W     = 33;
  localparam int NORM_RAD_W  = 64;
  localparam int ROOT_W      = 32;
  localparam int PROD_W      = 64;
  localparam int BLEND_W     = 50;
  localparam int BLEND_SH    = 16;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [Q_W-1:0]    q30_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef q30_t [3:0]               quat_t;

  // Sideband that rides along the first square root
  typedef struct packed {
    quat_t                pa;
    quat_t                pb;
    logic [WEIGHT_W-1:0]  weight;
  } norm1_side_t;

  // Sideband that rides along the first divider
  typedef struct packed {
    logic                 zero_a;
    logic                 zero_b;
    logic [WEIGHT_W-1:0]  weight;
  } div1_side_t;

endpackage

/* sv/qnl_if.sv */
interface qnl_in_if import qnl_pkg::*; ();
  logic                valid;
  logic                ready;
  comp_t               start_x;
  comp_t               start_y;
  comp_t               start_z;
  comp_t               start_w;
  comp_t               end_x;
  comp_t               end_y;
  comp_t               end_z;
  comp_t               end_w;
  logic [WEIGHT_W-1:0] blend_weight;

  modport source (
    output valid, start_x, start_y, start_z, start_w,
    output end_x, end_y, end_z, end_w, blend_weight,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_z, start_w,
    input  end_x, end_y, end_z, end_w, blend_weight,
    output ready
  );
endinterface

interface qnl_out_if import qnl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] row0_col0;
  logic signed [OUT_W-1:0] row0_col1;
  logic signed [OUT_W-1:0] row0_col2;
  logic signed [OUT_W-1:0] row1_col0;
  logic signed [OUT_W-1:0] row1_col1;
  logic signed [OUT_W-1:0] row1_col2;
  logic signed [OUT_W-1:0] row2_col0;
  logic signed [OUT_W-1:0] row2_col1;
  logic signed [OUT_W-1:0] row2_col2;

  modport source (
    output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
    output row1_col2, row2_col0, row2_col1, row2_col2,
    input  ready
  );
  modport sink (
    input  valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
    input  row1_col2, row2_col0, row2_col1, row2_col2,
    output ready
  );
endinterface

/* sv/quaternion_nlerp_to_matrix_core.sv */
// Quaternion blend to rotation matrix.
//
// in_chan carries two quaternions (Q1.15) and a blend weight (Q1.16); out_chan
// returns the nine elements of the transposed 3x3 rotation matrix in Q1.FRAC_BITS,
// saturated to plus or minus one. Both channels use valid/ready; a transfer
// happens on a rising edge with valid and ready high.
//
// Throughput: one item per cycle while the output is not stalled. The path
// runs through two normalizations, each a 32-stage square root (two radicand
// bits per stage) followed by a 31-stage divider (one quotient bit per stage),
// plus the squaring, blend and matrix stages around them.
//
// The whole pipeline advances together. When the output register holds a
// result the receiver does not take, every stage holds and in_chan.ready drops;
// nothing is lost or repeated. Reset (rst_n low, synchronous) clears all valid
// bits, so the pipeline comes up empty with in_chan.ready high.
module quaternion_nlerp_to_matrix_core import qnl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  qnl_in_if.sink    in_chan,
  qnl_out_if.source out_chan
);

  localparam int    RND_SH     = 2 * Q_FRAC - FRAC_BITS;
  localparam prod_t RND_HALF   = prod_t'(1) <<< (RND_SH - 1);
  localparam prod_t MAT_ONE    = prod_t'(1) <<< (2 * Q_FRAC);
  localparam prod_t OUT_LIM    = prod_t'(1) <<< FRAC_BITS;
  localparam q30_t  Q_ONE      = q30_t'(1) <<< Q_FRAC;
  localparam logic signed [BLEND_W-1:0] BLEND_HALF =
    (BLEND_W)'(1) <<< (BLEND_SH - 1);

  // Global advance: hold everything while the output waits
  logic en;
  logic s14_vld_r;
  assign en            = !s14_vld_r || out_chan.ready;
  assign in_chan.ready = en;

  // Valid chain of the stages owned here
  logic s1_vld_r, s2_vld_r, s3_vld_r;
  logic s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r, s8_vld_r, s9_vld_r;
  logic s10_vld_r, s11_vld_r, s12_vld_r, s13_vld_r;
  logic sq1_vld, dv1_vld, sq2_vld, dv2_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      s7_vld_r  <= 1'b0;
      s8_vld_r  <= 1'b0;
      s9_vld_r  <= 1'b0;
      s10_vld_r <= 1'b0;
      s11_vld_r <= 1'b0;
      s12_vld_r <= 1'b0;
      s13_vld_r <= 1'b0;
      s14_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_chan.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= dv1_vld;
      s5_vld_r  <= s4_vld_r;
      s6_vld_r  <= s5_vld_r;
      s7_vld_r  <= s6_vld_r;
      s8_vld_r  <= s7_vld_r;
      s9_vld_r  <= s8_vld_r;
      s10_vld_r <= dv2_vld;
      s11_vld_r <= s10_vld_r;
      s12_vld_r <= s11_vld_r;
      s13_vld_r <= s12_vld_r;
      s14_vld_r <= s13_vld_r;
    end
  end

  // Stage 1: input register
  comp_t               s1_a_r [4];
  comp_t               s1_b_r [4];
  logic [WEIGHT_W-1:0] s1_w_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r[0] <= in_chan.start_x;
      s1_a_r[1] <= in_chan.start_y;
      s1_a_r[2] <= in_chan.start_z;
      s1_a_r[3] <= in_chan.start_w;
      s1_b_r[0] <= in_chan.end_x;
      s1_b_r[1] <= in_chan.end_y;
      s1_b_r[2] <= in_chan.end_z;
      s1_b_r[3] <= in_chan.end_w;
      s1_w_r    <= in_chan.blend_weight;
    end
  end

  // Stage 2: square the components, clamp the weight
  logic signed [2*COMP_W-1:0] sqa_c [4];
  logic signed [2*COMP_W-1:0] sqb_c [4];
  logic [SQ_W-1:0]     s2_sqa_r [4];
  logic [SQ_W-1:0]     s2_sqb_r [4];
  comp_t               s2_a_r [4];
  comp_t               s2_b_r [4];
  logic [WEIGHT_W-1:0] s2_w_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sqa_c[i] = s1_a_r[i] * s1_a_r[i];
      sqb_c[i] = s1_b_r[i] * s1_b_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s2_sqa_r[i] <= sqa_c[i][SQ_W-1:0];
        s2_sqb_r[i] <= sqb_c[i][SQ_W-1:0];
        s2_a_r[i]   <= s1_a_r[i];
        s2_b_r[i]   <= s1_b_r[i];
      end
      s2_w_r <= (s1_w_r > WEIGHT_ONE) ? WEIGHT_ONE : s1_w_r;
    end
  end

  // Stage 3: sum of squares as radicand, components scaled to Q30
  logic [SUMSQ_W-1:0]    suma_c, sumb_c;
  logic [NORM_RAD_W-1:0] s3_rad_r [2];
  norm1_side_t           s3_side_r;

  always_comb begin
    suma_c = '0;
    sumb_c = '0;
    for (int i = 0; i < 4; i++) begin
      suma_c = suma_c + SUMSQ_W'(s2_sqa_r[i]);
      sumb_c = sumb_c + SUMSQ_W'(s2_sqb_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rad_r[0] <= NORM_RAD_W'({suma_c, {Q_FRAC{1'b0}}});
      s3_rad_r[1] <= NORM_RAD_W'({sumb_c, {Q_FRAC{1'b0}}});
      for (int i = 0; i < 4; i++) begin
        s3_side_r.pa[i] <= q30_t'(s2_a_r[i]) <<< IN_SHIFT;
        s3_side_r.pb[i] <= q30_t'(s2_b_r[i]) <<< IN_SHIFT;
      end
      s3_side_r.weight <= s2_w_r;
    end
  end

  // First normalization: square roots of both magnitudes
  logic [ROOT_W-1:0] root1 [2];
  norm1_side_t       sq1_side;

  qnl_isqrt #(
    .LANES  (2),
    .RAD_W  (NORM_RAD_W),
    .SIDE_W ($bits(norm1_side_t))
  ) u_isqrt1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_vld_r),
    .in_rad    (s3_rad_r),
    .in_side   (s3_side_r),
    .out_valid (sq1_vld),
    .out_root  (root1),
    .out_side  (sq1_side)
  );

  // Divide all eight components by their magnitude
  q30_t              num1 [8];
  logic [ROOT_W-1:0] den1 [8];
  q30_t              quo1 [8];
  div1_side_t        dv1_side_in, dv1_side;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num1[i]     = sq1_side.pa[i];
      num1[4 + i] = sq1_side.pb[i];
      den1[i]     = root1[0];
      den1[4 + i] = root1[1];
    end
    dv1_side_in.zero_a = (root1[0] == '0);
    dv1_side_in.zero_b = (root1[1] == '0);
    dv1_side_in.weight = sq1_side.weight;
  end

  qnl_div #(
    .LANES  (8),
    .SIDE_W ($bits(div1_side_t))
  ) u_div1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq1_vld),
    .in_num    (num1),
    .in_den    (den1),
    .in_side   (dv1_side_in),
    .out_valid (dv1_vld),
    .out_quo   (quo1),
    .out_side  (dv1_side)
  );

  // Stage 4: unit quaternions, a zero input stays zero
  q30_t                s4_qa_r [4];
  q30_t                s4_qb_r [4];
  logic [WEIGHT_W-1:0] s4_w_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s4_qa_r[i] <= dv1_side.zero_a ? '0 : quo1[i];
        s4_qb_r[i] <= dv1_side.zero_b ? '0 : quo1[4 + i];
      end
      s4_w_r <= dv1_side.weight;
    end
  end

  // Stage 5: dot product terms
  prod_t               dp_c [4];
  prod_t               s5_dp_r [4];
  q30_t                s5_qa_r [4];
  q30_t                s5_qb_r [4];
  logic [WEIGHT_W-1:0] s5_w_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dp_c[i] = s4_qa_r[i] * s4_qb_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_dp_r <= dp_c;
      s5_qa_r <= s4_qa_r;
      s5_qb_r <= s4_qb_r;
      s5_w_r  <= s4_w_r;
    end
  end

  // Stage 6: sign of the dot product, weighted terms
  prod_t                      dot_c;
  logic signed [WEIGHT_W:0]   wa_c, wb_c;
  logic signed [BLEND_W-1:0]  ta_c [4];
  logic signed [BLEND_W-1:0]  tb_c [4];
  logic                       s6_neg_r;
  logic signed [BLEND_W-1:0]  s6_ta_r [4];
  logic signed [BLEND_W-1:0]  s6_tb_r [4];

  always_comb begin
    dot_c = s5_dp_r[0] + s5_dp_r[1] + s5_dp_r[2] + s5_dp_r[3];
    wa_c  = $signed({1'b0, WEIGHT_ONE - s5_w_r});
    wb_c  = $signed({1'b0, s5_w_r});
    for (int i = 0; i < 4; i++) begin
      ta_c[i] = s5_qa_r[i] * wa_c;
      tb_c[i] = s5_qb_r[i] * wb_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_neg_r <= dot_c[PROD_W-1];
      s6_ta_r  <= ta_c;
      s6_tb_r  <= tb_c;
    end
  end

  // Stage 7: blend, round half up back to Q30
  logic signed [BLEND_W-1:0] acc_c [4];
  logic signed [BLEND_W-1:0] accsh_c [4];
  q30_t                      s7_r_r [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc_c[i]   = s6_ta_r[i] + (s6_neg_r ? -s6_tb_r[i] : s6_tb_r[i]) + BLEND_HALF;
      accsh_c[i] = acc_c[i] >>> BLEND_SH;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s7_r_r[i] <= accsh_c[i][Q_W-1:0];
      end
    end
  end

  // Stage 8: squares of the blend
  prod_t s8_sq_r [4];
  prod_t sq2_c [4];
  q30_t  s8_r_r [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq2_c[i] = s7_r_r[i] * s7_r_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_sq_r <= sq2_c;
      s8_r_r  <= s7_r_r;
    end
  end

  // Stage 9: magnitude squared of the blend
  logic [NORM_RAD_W-1:0] s9_rad_r [1];
  quat_t                 s9_r_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_rad_r[0] <= NORM_RAD_W'(s8_sq_r[0] + s8_sq_r[1] + s8_sq_r[2] + s8_sq_r[3]);
      for (int i = 0; i < 4; i++) begin
        s9_r_r[i] <= s8_r_r[i];
      end
    end
  end

  // Second normalization
  logic [ROOT_W-1:0] root2 [1];
  quat_t             sq2_side;

  qnl_isqrt #(
    .LANES  (1),
    .RAD_W  (NORM_RAD_W),
    .SIDE_W ($bits(quat_t))
  ) u_isqrt2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s9_vld_r),
    .in_rad    (s9_rad_r),
    .in_side   (s9_r_r),
    .out_valid (sq2_vld),
    .out_root  (root2),
    .out_side  (sq2_side)
  );

  q30_t              num2 [4];
  logic [ROOT_W-1:0] den2 [4];
  q30_t              quo2 [4];
  logic              zero2_in, zero2;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num2[i] = sq2_side[i];
      den2[i] = root2[0];
    end
    zero2_in = (root2[0] == '0);
  end

  qnl_div #(
    .LANES  (4),
    .SIDE_W (1)
  ) u_div2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq2_vld),
    .in_num    (num2),
    .in_den    (den2),
    .in_side   (zero2_in),
    .out_valid (dv2_vld),
    .out_quo   (quo2),
    .out_side  (zero2)
  );

  // Stage 10: blended unit quaternion x, y, z, w
  q30_t s10_q_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s10_q_r[i] <= zero2 ? '0 : quo2[i];
      end
    end
  end

  // Stage 11: the nine products; xx yy zz xy xz yz xw yw zw
  prod_t pr_c [9];
  prod_t s11_p_r [9];

  always_comb begin
    pr_c[0] = s10_q_r[0] * s10_q_r[0];
    pr_c[1] = s10_q_r[1] * s10_q_r[1];
    pr_c[2] = s10_q_r[2] * s10_q_r[2];
    pr_c[3] = s10_q_r[0] * s10_q_r[1];
    pr_c[4] = s10_q_r[0] * s10_q_r[2];
    pr_c[5] = s10_q_r[1] * s10_q_r[2];
    pr_c[6] = s10_q_r[0] * s10_q_r[3];
    pr_c[7] = s10_q_r[1] * s10_q_r[3];
    pr_c[8] = s10_q_r[2] * s10_q_r[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_p_r <= pr_c;
    end
  end

  // Stage 12: matrix elements in Q60, already in transposed order
  prod_t el_c [9];
  prod_t s12_e_r [9];

  always_comb begin
    el_c[0] = MAT_ONE - ((s11_p_r[1] + s11_p_r[2]) <<< 1);  // M00
    el_c[1] = (s11_p_r[3] + s11_p_r[8]) <<< 1;              // M10
    el_c[2] = (s11_p_r[4] - s11_p_r[7]) <<< 1;              // M20
    el_c[3] = (s11_p_r[3] - s11_p_r[8]) <<< 1;              // M01
    el_c[4] = MAT_ONE - ((s11_p_r[0] + s11_p_r[2]) <<< 1);  // M11
    el_c[5] = (s11_p_r[5] + s11_p_r[6]) <<< 1;              // M21
    el_c[6] = (s11_p_r[4] + s11_p_r[7]) <<< 1;              // M02
    el_c[7] = (s11_p_r[5] - s11_p_r[6]) <<< 1;              // M12
    el_c[8] = MAT_ONE - ((s11_p_r[0] + s11_p_r[1]) <<< 1);  // M22
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s12_e_r <= el_c;
    end
  end

  // Stage 13: round half up to the output scale
  prod_t rnd_c [9];
  prod_t s13_v_r [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rnd_c[i] = (s12_e_r[i] + RND_HALF) >>> RND_SH;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s13_v_r <= rnd_c;
    end
  end

  // Stage 14: saturate to plus or minus one, keep the low 16 bits
  prod_t            sat_c [9];
  logic [OUT_W-1:0] s14_m_r [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (s13_v_r[i] > OUT_LIM) begin
        sat_c[i] = OUT_LIM;
      end else if (s13_v_r[i] < -OUT_LIM) begin
        sat_c[i] = -OUT_LIM;
      end else begin
        sat_c[i] = s13_v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        s14_m_r[i] <= sat_c[i][OUT_W-1:0];
      end
    end
  end

  assign out_chan.valid     = s14_vld_r;
  assign out_chan.row0_col0 = s14_m_r[0];
  assign out_chan.row0_col1 = s14_m_r[1];
  assign out_chan.row0_col2 = s14_m_r[2];
  assign out_chan.row1_col0 = s14_m_r[3];
  assign out_chan.row1_col1 = s14_m_r[4];
  assign out_chan.row1_col2 = s14_m_r[5];
  assign out_chan.row2_col0 = s14_m_r[6];
  assign out_chan.row2_col1 = s14_m_r[7];
  assign out_chan.row2_col2 = s14_m_r[8];

  // Normalized values never exceed one in Q30
  logic q1_ok, q2_ok;

  always_comb begin
    q1_ok = 1'b1;
    q2_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (s4_qa_r[i] > Q_ONE || s4_qa_r[i] < -Q_ONE) q1_ok = 1'b0;
      if (s4_qb_r[i] > Q_ONE || s4_qb_r[i] < -Q_ONE) q1_ok = 1'b0;
      if (s10_q_r[i] > Q_ONE || s10_q_r[i] < -Q_ONE) q2_ok = 1'b0;
    end
  end

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |-> !in_chan.ready)
    else $error("input accepted while output stalled");

  a_norm1_range : assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r |-> q1_ok)
    else $error("first normalization out of range");

  a_norm2_range : assert property (@(posedge clk) disable iff (!rst_n)
    s10_vld_r |-> q2_ok)
    else $error("second normalization out of range");

  a_stall_holds_result : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s13_vld_r) && $stable(s4_vld_r))
    else $error("pipeline moved during stall");

endmodule

/* sv/qnl_isqrt.sv */
module qnl_isqrt import qnl_pkg::*; #(
  parameter int LANES  = 1,
  parameter int RAD_W  = NORM_RAD_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad [LANES],
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RAD_W/2-1:0] out_root [LANES],
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = RAD_W / 2;
  localparam int RT_W  = RAD_W / 2;
  localparam int REM_W = RT_W + 3;

  logic              vld_r  [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];
  logic [RT_W-1:0]   root_r [STEPS][LANES];
  logic [REM_W-1:0]  rem_r  [STEPS-1][LANES];
  logic [RAD_W-1:0]  rad_r  [STEPS-1][LANES];

  // One result bit per stage, two radicand bits consumed
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic              vld_i;
    logic [SIDE_W-1:0] side_i;
    logic [RT_W-1:0]   root_i [LANES];
    logic [REM_W-1:0]  rem_i  [LANES];
    logic [RAD_W-1:0]  rad_i  [LANES];
    logic [REM_W-1:0]  remsh  [LANES];
    logic [REM_W-1:0]  trial  [LANES];
    logic              ge     [LANES];
    logic [REM_W-1:0]  rem_nxt [LANES];

    if (k == 0) begin : g_head
      always_comb begin
        vld_i  = in_valid;
        side_i = in_side;
        for (int l = 0; l < LANES; l++) begin
          root_i[l] = '0;
          rem_i[l]  = '0;
          rad_i[l]  = in_rad[l];
        end
      end
    end else begin : g_body
      always_comb begin
        vld_i  = vld_r[k-1];
        side_i = side_r[k-1];
        for (int l = 0; l < LANES; l++) begin
          root_i[l] = root_r[k-1][l];
          rem_i[l]  = rem_r[k-1][l];
          rad_i[l]  = rad_r[k-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        remsh[l]   = {rem_i[l][REM_W-3:0], rad_i[l][RAD_W-1 -: 2]};
        trial[l]   = {1'b0, root_i[l], 2'b01};
        ge[l]      = remsh[l] >= trial[l];
        rem_nxt[l] = ge[l] ? remsh[l] - trial[l] : remsh[l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_i;
        for (int l = 0; l < LANES; l++) begin
          root_r[k][l] <= {root_i[l][RT_W-2:0], ge[l]};
        end
      end
    end

    if (k < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          for (int l = 0; l < LANES; l++) begin
            rem_r[k][l] <= rem_nxt[l];
            rad_r[k][l] <= {rad_i[l][RAD_W-3:0], 2'b00};
          end
        end
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_root[l] = root_r[STEPS-1][l];
    end
  end

endmodule

/* sv/qnl_div.sv */
module qnl_div import qnl_pkg::*; #(
  parameter int LANES  = 4,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  q30_t              in_num [LANES],
  input  logic [ROOT_W-1:0] in_den [LANES],
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output q30_t              out_quo [LANES],
  output logic [SIDE_W-1:0] out_side
);

  // Quotient of num * 2^30 / den, with |num| <= den so it stays within 31 bits
  localparam int STEPS = QMAG_W;
  localparam int REM_W = ROOT_W + 1;

  logic              vld_r  [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];
  logic [QMAG_W-1:0] quo_r  [STEPS][LANES];
  logic              neg_r  [STEPS][LANES];
  logic [REM_W-1:0]  rem_r  [STEPS-1][LANES];
  logic [ROOT_W-1:0] den_r  [STEPS-1][LANES];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic              vld_i;
    logic [SIDE_W-1:0] side_i;
    logic [QMAG_W-1:0] quo_i [LANES];
    logic              neg_i [LANES];
    logic [REM_W-1:0]  rem_i [LANES];
    logic [ROOT_W-1:0] den_i [LANES];
    logic              ge    [LANES];
    logic [REM_W-1:0]  diff  [LANES];

    if (k == 0) begin : g_head
      q30_t absn [LANES];
      always_comb begin
        vld_i  = in_valid;
        side_i = in_side;
        for (int l = 0; l < LANES; l++) begin
          absn[l]  = in_num[l][Q_W-1] ? -in_num[l] : in_num[l];
          neg_i[l] = in_num[l][Q_W-1];
          quo_i[l] = '0;
          rem_i[l] = REM_W'(absn[l][QMAG_W-1:0]);
          den_i[l] = in_den[l];
        end
      end
    end else begin : g_body
      always_comb begin
        vld_i  = vld_r[k-1];
        side_i = side_r[k-1];
        for (int l = 0; l < LANES; l++) begin
          neg_i[l] = neg_r[k-1][l];
          quo_i[l] = quo_r[k-1][l];
          rem_i[l] = rem_r[k-1][l];
          den_i[l] = den_r[k-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        ge[l]   = rem_i[l] >= REM_W'(den_i[l]);
        diff[l] = ge[l] ? rem_i[l] - REM_W'(den_i[l]) : rem_i[l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_i;
        for (int l = 0; l < LANES; l++) begin
          quo_r[k][l] <= {quo_i[l][QMAG_W-2:0], ge[l]};
          neg_r[k][l] <= neg_i[l];
        end
      end
    end

    if (k < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          for (int l = 0; l < LANES; l++) begin
            rem_r[k][l] <= {diff[l][REM_W-2:0], 1'b0};
            den_r[k][l] <= den_i[l];
          end
        end
      end
    end
  end

  // Restore the sign, truncating toward zero
  q30_t mag_o [LANES];
  assign out_valid = vld_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag_o[l]   = q30_t'({1'b0, quo_r[STEPS-1][l]});
      out_quo[l] = neg_r[STEPS-1][l] ? -mag_o[l] : mag_o[l];
    end
  end

endmodule
